[rtl/two_objective_pareto_filter_defines.svh]
// ----------------------------------------------------------------------------
// Pareto filter assertion macros
// Shared assertion forms for the two-objective Pareto filter.
// ----------------------------------------------------------------------------
`ifndef TWO_OBJECTIVE_PARETO_FILTER_DEFINES_SVH
`define TWO_OBJECTIVE_PARETO_FILTER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define POF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pof_pkg.sv]
// ----------------------------------------------------------------------------
// Pareto filter package
// Control bundle driven from the sequencer to every storage cell.
// ----------------------------------------------------------------------------
package pof_pkg;

  typedef struct packed {
    logic clear;   // drop all entries
    logic shift;   // take neighbor contents
    logic wr_en;   // load the write bus into the addressed cell
    logic probe;   // latch dominance flags against the write bus costs
  } pof_ctl_t;

endpackage

[rtl/pof_cell.sv]
// ----------------------------------------------------------------------------
// Pareto filter cell
// One set slot: entry storage, shift from the upper neighbor, addressed
// write, and local dominance compare against the broadcast costs.
// ----------------------------------------------------------------------------
module pof_cell #(
  parameter int ID_BITS   = 10,
  parameter int COST_BITS = 24,
  parameter int PTR_W     = 4,
  parameter int SLOT      = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pof_pkg::pof_ctl_t    ctl,
  input  logic [PTR_W-1:0]     wr_idx,
  input  logic [ID_BITS-1:0]   wr_id,
  input  logic [COST_BITS-1:0] wr_a,
  input  logic [COST_BITS-1:0] wr_b,
  input  logic                 nb_valid,
  input  logic [ID_BITS-1:0]   nb_id,
  input  logic [COST_BITS-1:0] nb_a,
  input  logic [COST_BITS-1:0] nb_b,
  output logic                 valid,
  output logic [ID_BITS-1:0]   id,
  output logic [COST_BITS-1:0] cost_a,
  output logic [COST_BITS-1:0] cost_b,
  output logic                 dom,
  output logic                 keep
);
  import pof_pkg::*;

  localparam logic [PTR_W-1:0] SLOT_IDX = PTR_W'(SLOT);

  logic wr_hit;

  assign wr_hit = ctl.wr_en && (wr_idx == SLOT_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dom   <= 1'b0;
      keep  <= 1'b0;
    end else begin
      if (wr_hit) begin
        valid <= 1'b1;
      end else if (ctl.clear) begin
        valid <= 1'b0;
      end else if (ctl.shift) begin
        valid <= nb_valid;
      end
      if (ctl.probe) begin
        dom  <= valid && (cost_a <= wr_a) && (cost_b <= wr_b);
        keep <= valid && ((wr_a > cost_a) || (wr_b > cost_b));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      id     <= wr_id;
      cost_a <= wr_a;
      cost_b <= wr_b;
    end else if (ctl.shift) begin
      id     <= nb_id;
      cost_a <= nb_a;
      cost_b <= nb_b;
    end
  end

endmodule

[rtl/two_objective_pareto_filter.sv]
// ----------------------------------------------------------------------------
// Two-objective Pareto filter
// Keeps a bounded set of non-dominated entries in a chain of cells.
//
//   port group  dir  tdata (low bit up)                 tuser / tlast
//   s_axis      in   entry_id, cost_a, cost_b           tuser: seed, emit_after
//   m_axis      out  member_id, member_cost_a, _cost_b  tuser: member_valid,
//                                                       overflowed; tlast: last
//
// Seed, dominated offer or full set: states IDLE, CMP, DEC. Accepted offer adds
// one rewrite sweep of the cell chain in S_PASS (one slot per cycle).
// Readout rotates the chain through every slot in S_EMIT, stretched by m_axis
// stalls; an empty set gives one beat. One item at a time; the output
// register lets the next item in while the last beat waits.
// Synchronous reset empties the set and clears the overflow flag at once.
// ----------------------------------------------------------------------------
module two_objective_pareto_filter #(
  parameter int SET_CAPACITY = 16,
  parameter int ID_BITS      = 10,
  parameter int COST_BITS    = 24,
  localparam int FIELD_W     = ID_BITS + 2 * COST_BITS,
  localparam int TDATA_W     = ((FIELD_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // entry_id, cost_a, cost_b
  input  logic [1:0]         s_axis_tuser,   // seed, emit_after
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // member_id, member_cost_a, member_cost_b
  output logic [1:0]         m_axis_tuser,   // member_valid, overflowed
  output logic               m_axis_tlast
);
  import pof_pkg::*;

  `include "two_objective_pareto_filter_defines.svh"

  localparam int PTR_W = $clog2(SET_CAPACITY);
  localparam int CNT_W = $clog2(SET_CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_DEC  = 5'b00100,
    S_PASS = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state;

  logic [ID_BITS-1:0]   it_id;
  logic [COST_BITS-1:0] it_a;
  logic [COST_BITS-1:0] it_b;
  logic                 it_seed;
  logic                 it_emit;

  logic                 hold_valid;
  logic [ID_BITS-1:0]   hold_id;
  logic [COST_BITS-1:0] hold_a;
  logic [COST_BITS-1:0] hold_b;

  logic [CNT_W-1:0]     wcnt;
  logic [CNT_W-1:0]     tcnt;
  logic [PTR_W-1:0]     ecnt;
  logic [CNT_W-1:0]     member_count;
  logic                 ovf;

  logic                 out_valid;
  logic                 out_load;
  logic [ID_BITS-1:0]   out_id;
  logic [COST_BITS-1:0] out_a;
  logic [COST_BITS-1:0] out_b;
  logic                 out_mv;
  logic                 out_last;
  logic                 out_ovf;

  pof_ctl_t             ctl;
  logic [PTR_W-1:0]     wr_idx;
  logic [ID_BITS-1:0]   wr_id;
  logic [COST_BITS-1:0] wr_a;
  logic [COST_BITS-1:0] wr_b;
  logic                 tail_rot;

  logic                 cell_valid [SET_CAPACITY];
  logic [ID_BITS-1:0]   cell_id    [SET_CAPACITY];
  logic [COST_BITS-1:0] cell_a     [SET_CAPACITY];
  logic [COST_BITS-1:0] cell_b     [SET_CAPACITY];
  logic                 nb_valid   [SET_CAPACITY];
  logic [ID_BITS-1:0]   nb_id      [SET_CAPACITY];
  logic [COST_BITS-1:0] nb_a       [SET_CAPACITY];
  logic [COST_BITS-1:0] nb_b       [SET_CAPACITY];
  logic [SET_CAPACITY-1:0] dom_vec;
  logic [SET_CAPACITY-1:0] keep_vec;

  logic                 any_dom;
  logic                 all_keep;
  logic                 c0_keep;
  logic                 tail_cyc;
  logic [CNT_W:0]       pass_pos;
  logic                 can_load;
  logic                 in_list;
  logic                 emit_adv;
  logic                 s_accept;
  state_t               after_state;

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    if (i == SET_CAPACITY - 1) begin : g_tail
      assign nb_valid[i] = tail_rot && cell_valid[0];
      assign nb_id[i]    = cell_id[0];
      assign nb_a[i]     = cell_a[0];
      assign nb_b[i]     = cell_b[0];
    end else begin : g_link
      assign nb_valid[i] = cell_valid[i+1];
      assign nb_id[i]    = cell_id[i+1];
      assign nb_a[i]     = cell_a[i+1];
      assign nb_b[i]     = cell_b[i+1];
    end

    pof_cell #(
      .ID_BITS   (ID_BITS),
      .COST_BITS (COST_BITS),
      .PTR_W     (PTR_W),
      .SLOT      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .wr_idx   (wr_idx),
      .wr_id    (wr_id),
      .wr_a     (wr_a),
      .wr_b     (wr_b),
      .nb_valid (nb_valid[i]),
      .nb_id    (nb_id[i]),
      .nb_a     (nb_a[i]),
      .nb_b     (nb_b[i]),
      .valid    (cell_valid[i]),
      .id       (cell_id[i]),
      .cost_a   (cell_a[i]),
      .cost_b   (cell_b[i]),
      .dom      (dom_vec[i]),
      .keep     (keep_vec[i])
    );
  end

  // ------------------------------------------------------------- control
  assign any_dom  = |dom_vec;
  assign all_keep = &keep_vec;
  assign c0_keep  = cell_valid[0] && ((it_a > cell_a[0]) || (it_b > cell_b[0]));

  // slot that lands at rank wcnt once the remaining sweep shifts are done
  assign tail_cyc = (tcnt == CNT_W'(SET_CAPACITY));
  assign pass_pos = tail_cyc ? {1'b0, wcnt}
                             : {1'b0, wcnt} + (CNT_W+1)'(SET_CAPACITY - 1) - {1'b0, tcnt};

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign can_load      = !out_valid || m_axis_tready;
  assign in_list       = (CNT_W'(ecnt) < member_count);
  assign emit_adv      = in_list ? can_load : 1'b1;
  assign after_state   = it_emit ? S_EMIT : S_IDLE;
  assign out_load      = (state == S_EMIT) && can_load &&
                         ((member_count == '0) || in_list);

  always_comb begin
    ctl      = '0;
    wr_idx   = '0;
    wr_id    = it_id;
    wr_a     = it_a;
    wr_b     = it_b;
    tail_rot = 1'b0;
    case (state)
      S_CMP: begin
        ctl.probe = 1'b1;
      end
      S_DEC: begin
        if (it_seed) begin
          ctl.clear = 1'b1;
          ctl.wr_en = 1'b1;
        end else if (!any_dom && !all_keep) begin
          ctl.shift = 1'b1;
          ctl.wr_en = 1'b1;
          wr_idx    = PTR_W'(SET_CAPACITY - 1);
        end
      end
      S_PASS: begin
        ctl.shift = !tail_cyc;
        ctl.wr_en = hold_valid;
        wr_idx    = pass_pos[PTR_W-1:0];
        wr_id     = hold_id;
        wr_a      = hold_a;
        wr_b      = hold_b;
      end
      S_EMIT: begin
        ctl.shift = emit_adv && (member_count != '0);
        tail_rot  = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      member_count <= '0;
      ovf          <= 1'b0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !m_axis_tready);
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_DEC;
        end
        S_DEC: begin
          if (it_seed) begin
            member_count <= CNT_W'(1);
            ovf          <= 1'b0;
            state        <= after_state;
          end else if (any_dom) begin
            state <= after_state;
          end else if (all_keep) begin
            ovf   <= 1'b1;
            state <= after_state;
          end else begin
            hold_valid <= c0_keep;
            state      <= S_PASS;
          end
        end
        S_PASS: begin
          hold_valid <= c0_keep;
          if (tail_cyc) begin
            member_count <= wcnt + CNT_W'(hold_valid);
            state        <= after_state;
          end
        end
        S_EMIT: begin
          if (member_count == '0) begin
            if (can_load) begin
              state <= S_IDLE;
            end
          end else if (emit_adv) begin
            if (ecnt == PTR_W'(SET_CAPACITY - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    if (s_accept) begin
      it_id   <= s_axis_tdata[ID_BITS-1:0];
      it_a    <= s_axis_tdata[ID_BITS+COST_BITS-1:ID_BITS];
      it_b    <= s_axis_tdata[FIELD_W-1:ID_BITS+COST_BITS];
      it_seed <= s_axis_tuser[0];
      it_emit <= s_axis_tuser[1];
    end
    if (state == S_DEC || state == S_PASS) begin
      hold_id <= cell_id[0];
      hold_a  <= cell_a[0];
      hold_b  <= cell_b[0];
    end
    if (state == S_DEC) begin
      wcnt <= CNT_W'(1);
      tcnt <= CNT_W'(1);
    end else if (state == S_PASS) begin
      if (hold_valid) begin
        wcnt <= wcnt + CNT_W'(1);
      end
      tcnt <= tcnt + CNT_W'(1);
    end
    if (state != S_EMIT) begin
      ecnt <= '0;
    end else if (emit_adv && (member_count != '0)) begin
      ecnt <= ecnt + PTR_W'(1);
    end
    if (state == S_EMIT && can_load) begin
      if (member_count == '0) begin
        out_id   <= '0;
        out_a    <= '0;
        out_b    <= '0;
        out_mv   <= 1'b0;
        out_last <= 1'b1;
        out_ovf  <= ovf;
      end else if (in_list) begin
        out_id   <= cell_id[0];
        out_a    <= cell_a[0];
        out_b    <= cell_b[0];
        out_mv   <= 1'b1;
        out_last <= (CNT_W'(ecnt) + CNT_W'(1) == member_count);
        out_ovf  <= ovf;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'({out_b, out_a, out_id});
  assign m_axis_tuser  = {out_ovf, out_mv};
  assign m_axis_tlast  = out_last;

  // ---------------------------------------------------------- assertions
  `POF_ASSERT_NOW(a_count_bound, 1'b1, member_count <= CNT_W'(SET_CAPACITY),
    "member count above capacity")
  `POF_ASSERT_NOW(a_pass_slot, (state == S_PASS) && hold_valid,
    pass_pos < (CNT_W+1)'(SET_CAPACITY), "sweep write outside the chain")
  `POF_ASSERT_NEXT(a_seed_count, (state == S_DEC) && it_seed,
    member_count == CNT_W'(1), "seed did not leave a single member")
  `POF_ASSERT_NOW(a_empty_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast,
    "empty readout beat without last")

endmodule
